// ===== src/tves_pkg.sv =====
// Package for the triangular velocity motion slot block.
// Item types, action codes, widths and the front/back hand-off record.
// No dependencies.
`timescale 1ns / 1ps
package tves_pkg;

  localparam int unsigned SlotCountDefault = 16;
  localparam int unsigned PosW  = 32;
  localparam int unsigned SpdW  = 48;
  localparam int unsigned DurW  = 16;
  localparam int unsigned IdxW  = 4;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] start_position;
    logic signed [31:0] end_position;
    logic [15:0]        duration_frames;
    logic [3:0]         read_slot;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         slot_index;
    logic signed [31:0] position_out;
    logic               table_full;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    action_e            act;
    logic signed [31:0] start_pos;
    logic signed [31:0] end_pos;
    logic [15:0]        dur;
    logic [3:0]         rd_slot;
  } cmd_t;

endpackage

// ===== src/tves_divider.sv =====
// Restoring divider for the step magnitude: (|diff| << 18) / dur^2.
// Uses tves_pkg widths; one quotient bit per cycle.
`timescale 1ns / 1ps
module tves_divider
  import tves_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [32:0]     mag_i,
  input  logic [15:0]     dur_i,
  output logic            done_o,
  output logic [SpdW-1:0] quot_o
);

  localparam int unsigned NumW = 51;

  logic [NumW-1:0] num_q, num_d;
  logic [31:0]     den_q, den_d;
  logic [32:0]     rem_q, rem_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [50:0]     quo_q, quo_d;
  logic [32:0]     trial;
  logic [33:0]     diffv;

  // One shift-subtract step per cycle
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    trial  = {rem_q[31:0], num_q[NumW-1]};
    diffv  = {1'b0, trial} - {2'b00, den_q};
    if (go_i) begin
      num_d  = {mag_i, 18'd0};
      den_d  = 32'(dur_i) * 32'(dur_i);
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (!diffv[33]) begin
        rem_d = diffv[32:0];
        quo_d = {quo_q[49:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[49:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // Saturate to 2^47 - 1
  assign quot_o = (|quo_q[50:47]) ? {1'b0, {(SpdW-1){1'b1}}} : quo_q[SpdW-1:0];
  assign done_o = done_q;

endmodule

// ===== src/tves_front.sv =====
// Front end: accepts items and queues classified commands for the back end.
// Uses tves_pkg types; two-entry queue.
`timescale 1ns / 1ps
module tves_front
  import tves_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  in_item_t item_i,
  output logic     busy_o,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;
  cmd_t       cmd_new;

  // Classify the incoming item
  always_comb begin
    cmd_new.act       = action_e'(item_i.action);
    cmd_new.start_pos = item_i.start_position;
    cmd_new.end_pos   = item_i.end_position;
    cmd_new.dur       = item_i.duration_frames;
    cmd_new.rd_slot   = item_i.read_slot;
  end

  assign busy_o      = (fill_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

// ===== src/tves_back.sv =====
// Back end: slot table and sequencer for tick, start and read.
// Uses tves_pkg and tves_divider; walks slots one at a time on a tick, a read state then a write state per slot.
`timescale 1ns / 1ps
module tves_back
  import tves_pkg::*;
#(
  parameter int unsigned SlotCount = SlotCountDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      res_valid_o,
  output out_item_t res_o
);

  localparam int unsigned SW = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TICK_RD, ST_TICK_WR, ST_DIV, ST_READ_RD, ST_READ
  } bstate_e;

  bstate_e state_q, state_d;

  logic [SlotCount-1:0] active_q;
  logic [SlotCount-1:0] pvalid_q;
  logic signed [PosW-1:0] pos_mem  [SlotCount];
  logic signed [SpdW-1:0] spd_mem  [SlotCount];
  logic signed [SpdW-1:0] step_mem [SlotCount];
  logic signed [PosW-1:0] end_mem  [SlotCount];
  logic [DurW-1:0]        dur_mem  [SlotCount];
  logic [DurW-1:0]        cnt_mem  [SlotCount];

  logic [SW:0]   idx_q, idx_d;
  logic [SW-1:0] slot;
  cmd_t          cmd_q;

  // Registered read of one slot
  logic signed [PosW-1:0] r_pos;
  logic signed [SpdW-1:0] r_spd, r_step;
  logic signed [PosW-1:0] r_end;
  logic [DurW-1:0]        r_dur, r_cnt;
  logic                   r_act, r_pv;

  logic signed [PosW-1:0] w_pos;
  logic signed [SpdW-1:0] w_spd;
  logic [DurW-1:0]        w_cnt;
  logic signed [33:0]     pos_sum;
  logic signed [49:0]     spd_sum;
  logic signed [32:0]     spd_fl;
  logic signed [PosW-1:0] cur_pos;
  logic                   wr_tick;

  logic                   free_found;
  logic [SW-1:0]          free_idx;
  logic signed [32:0]     diff;
  logic [32:0]            mag;
  logic                   div_go, div_done;
  logic [SpdW-1:0]        quot;
  logic                   res_v_d;
  out_item_t              res_d, res_q;
  logic                   res_v_q;
  logic                   claim;

  assign slot = idx_q[SW-1:0];

  tves_divider u_div (
    .clk_i (clk_i), .rst_ni(rst_ni), .go_i(div_go),
    .mag_i (mag), .dur_i(cmd_q.dur), .done_o(div_done), .quot_o(quot)
  );

  assign diff = 33'(cmd_q.end_pos) - 33'(cmd_q.start_pos);
  assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_pos  <= pos_mem[slot];
    r_spd  <= spd_mem[slot];
    r_step <= step_mem[slot];
    r_end  <= end_mem[slot];
    r_dur  <= dur_mem[slot];
    r_cnt  <= cnt_mem[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_act <= 1'b0;
      r_pv  <= 1'b0;
    end else begin
      r_act <= active_q[slot];
      r_pv  <= pvalid_q[slot];
    end
  end

  // Per-slot frame update
  always_comb begin
    cur_pos = r_pv ? r_pos : '0;
    spd_fl  = 33'(r_spd >>> 16);
    pos_sum = 34'(cur_pos) + 34'(spd_fl);
    spd_sum = '0;
    if (r_cnt < r_dur) begin
      if (pos_sum > 34'sh7FFFFFFF)       w_pos = 32'sh7FFFFFFF;
      else if (pos_sum < -34'sh80000000) w_pos = 32'sh80000000;
      else                               w_pos = pos_sum[PosW-1:0];
      if ((17'(r_cnt) << 1) < 17'(r_dur)) spd_sum = 50'(r_spd) + 50'(r_step);
      else                                spd_sum = 50'(r_spd) - 50'(r_step);
      if (spd_sum > 50'sh7FFFFFFFFFFF)       w_spd = {1'b0, {(SpdW-1){1'b1}}};
      else if (spd_sum < -50'sh800000000000) w_spd = {1'b1, {(SpdW-1){1'b0}}};
      else                                   w_spd = spd_sum[SpdW-1:0];
    end else begin
      w_pos = r_end;
      w_spd = r_spd;
    end
    w_cnt = (r_cnt == '1) ? r_cnt : r_cnt + 16'd1;
  end

  assign wr_tick = (state_q == ST_TICK_WR) && r_act;
  assign claim   = (state_q == ST_DIV) && div_done;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_pop_o = 1'b0;
    res_v_d   = 1'b0;
    res_d     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.act)
            ACT_TICK: begin
              idx_d   = '0;
              state_d = ST_TICK_RD;
            end
            ACT_START: state_d = ST_DIV;
            ACT_READ: begin
              idx_d   = (SW+1)'(cmd_i.rd_slot);
              state_d = ST_READ_RD;
            end
            default: res_v_d = 1'b1;
          endcase
        end
      end
      ST_TICK_RD: state_d = ST_TICK_WR;
      ST_TICK_WR: begin
        if (idx_q == (SW+1)'(SlotCount - 1)) begin
          res_v_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_TICK_RD;
        end
      end
      ST_DIV: begin
        if (!free_found) begin
          res_v_d          = 1'b1;
          res_d.table_full = 1'b1;
          state_d          = ST_IDLE;
        end else if (div_done) begin
          res_v_d          = 1'b1;
          res_d.slot_index = 4'(free_idx);
          state_d          = ST_IDLE;
        end
      end
      // Slot address settles; position lands in r_pos at the end of this cycle
      ST_READ_RD: state_d = ST_READ;
      ST_READ: begin
        res_v_d = 1'b1;
        if (32'(cmd_q.rd_slot) < SlotCount)
          res_d.position_out = r_pv ? r_pos : '0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Divider start: first cycle in ST_DIV only
  logic div_started_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_started_q <= 1'b0;
    else         div_started_q <= (state_q == ST_DIV) && !claim;
  end
  assign div_go = (state_q == ST_DIV) && !div_started_q && free_found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      active_q <= '0;
      pvalid_q <= '0;
      res_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      res_v_q <= res_v_d;
      if (claim) begin
        active_q[free_idx] <= 1'b1;
        pvalid_q[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    res_q <= res_d;
  end

  // Slot table writes
  always_ff @(posedge clk_i) begin
    if (wr_tick) begin
      pos_mem[slot] <= w_pos;
      spd_mem[slot] <= w_spd;
      cnt_mem[slot] <= w_cnt;
    end else if (claim) begin
      pos_mem[free_idx]  <= cmd_q.start_pos;
      spd_mem[free_idx]  <= '0;
      cnt_mem[free_idx]  <= '0;
      step_mem[free_idx] <= (cmd_q.dur == '0) ? '0 : (diff[32] ? -quot : quot);
      end_mem[free_idx]  <= cmd_q.end_pos;
      dur_mem[free_idx]  <= cmd_q.dur;
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule

// ===== src/triangular_velocity_easing_slots.sv =====
// Top level of the triangular velocity motion slot block.
// Instantiates tves_front and tves_back; uses tves_pkg.
//
// Usage: drive item_i and raise start; the item is taken on a clock edge
// where start is high and busy is low. A two-entry command queue sits
// between the front end and the slot sequencer, so up to two items wait.
// Each item gives exactly one result on result_o, marked by done_o for one
// cycle; the receiver cannot stall it.
// A start runs the step divider, one quotient bit per cycle over 51
// bits, unless the table is full; a tick walks the slot table one slot
// per read/write state pair.
// Reset clears all slot active bits and zero-position flags immediately;
// no clearing pass is needed, and items are taken right after reset.
`timescale 1ns / 1ps
module triangular_velocity_easing_slots
  import tves_pkg::*;
#(
  parameter int unsigned SlotCount = SlotCountDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      done_o,
  output out_item_t result_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  tves_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .item_i(item_i),
    .busy_o(busy), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  tves_back #(.SlotCount(SlotCount)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_pop_o(cmd_pop), .res_valid_o(done_o), .res_o(result_o)
  );

  // A full-table result never names a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.table_full |-> result_o.slot_index == '0)
    else $error("full result carries slot index");

  // Results never carry position and slot together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.slot_index != '0 |-> result_o.position_out == '0)
    else $error("start result carries position");

  // Queue pop only when a command waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty command queue");

endmodule
